// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== rtl/core/pstk_pkg.sv =====
`default_nettype none

package pstk_pkg;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_INSERT = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_UNDER  = 2'd2,
		ST_NOTERM = 2'd3
	} status_t;

	typedef struct packed {
		logic [4:0]  symbol;
		logic [3:0]  data_type;
		logic [15:0] code_handle;
		logic [7:0]  origin_tag;
	} entry_t;

	typedef struct packed {
		op_t         operation;
		logic [4:0]  symbol;
		logic [3:0]  data_type;
		logic [15:0] code_handle;
		logic [7:0]  origin_tag;
		logic [6:0]  pop_count;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  depth;
		logic        top_valid;
		logic [4:0]  top_symbol;
		logic [3:0]  top_data_type;
		logic [15:0] top_code_handle;
		logic [7:0]  top_origin_tag;
		logic        terminal_found;
		logic [4:0]  terminal_symbol;
		logic [3:0]  terminal_data_type;
		logic [15:0] terminal_code_handle;
		logic [7:0]  terminal_origin_tag;
	} out_t;

	// Write strobes broadcast to every cell.
	typedef struct packed {
		logic push_go;
		logic insert_go;
	} ctl_t;

	// Handed from a cell to the cell above it.
	typedef struct packed {
		entry_t entry;
		logic   mine;   // this cell holds the topmost terminal
		logic   shift;  // this cell's entry moves up into the cell above on an insert
		logic   le;     // a terminal sits at or below this cell
	} up_link_t;

	// Handed from a cell to the cell below it.
	typedef struct packed {
		logic   ge;        // a terminal sits at or above this cell
		entry_t top_acc;   // top entry gathered so far
		entry_t term_acc;  // topmost terminal gathered so far
	} down_link_t;

endpackage

`default_nettype wire

// ===== rtl/core/pstk_cell.sv =====
`default_nettype none

module pstk_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  wire logic                 clk,
	input  wire logic [4:0]           limit,
	input  wire logic [CNT_W-1:0]     count,
	input  wire pstk_pkg::ctl_t       ctl,
	input  wire pstk_pkg::entry_t     wr_entry,
	input  wire pstk_pkg::up_link_t   up_in,
	input  wire pstk_pkg::down_link_t down_in,
	output pstk_pkg::up_link_t        up_out,
	output pstk_pkg::down_link_t      down_out
);
	import pstk_pkg::*;

	entry_t entry_q;
	logic   occ;
	logic   tm;
	logic   ge_here;
	logic   is_top;
	logic   mine;

	assign occ     = CNT_W'(IDX) < count;
	assign tm      = occ && (entry_q.symbol < limit);
	assign ge_here = down_in.ge | tm;
	assign mine    = tm & ~down_in.ge;
	assign is_top  = count == CNT_W'(IDX + 1);

	assign up_out.entry = entry_q;
	assign up_out.mine  = mine;
	assign up_out.shift = ~ge_here & up_in.le;
	assign up_out.le    = up_in.le | tm;

	assign down_out.ge       = ge_here;
	assign down_out.top_acc  = entry_t'(down_in.top_acc | (is_top ? entry_q : '0));
	assign down_out.term_acc = entry_t'(down_in.term_acc | (mine ? entry_q : '0));

	// Take a pushed entry, the neighbor below on a shift, or the marker.
	always_ff @(posedge clk) begin
		priority if (ctl.push_go && count == CNT_W'(IDX)) begin
			entry_q <= wr_entry;
		end else if (ctl.insert_go && up_in.shift) begin
			entry_q <= up_in.entry;
		end else if (ctl.insert_go && up_in.mine) begin
			entry_q <= wr_entry;
		end else begin
			entry_q <= entry_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/precedence_parse_stack_top.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------
// in       | into      | in_valid / in_stall | pstk_pkg::in_t  (one operation)
// out      | out of    | out_valid/out_stall | pstk_pkg::out_t (one result)
// cfg      | into      | cfg_we              | cfg_wdata (terminal limit)
//
// An operation is applied to the cell row at the edge that accepts it; the
// result is then read from the row and registered once the output is free.
// While the output moves a transaction is taken every cycle; a stalled
// output holds one result plus one applied operation, then stalls the input.
// The terminal search ripples one OR per cell across the row, each way.
// Reset empties the stack and sets the terminal limit to 16; cells have no reset.
`default_nettype none
`include "assert_macros.svh"

module precedence_parse_stack_top #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [4:0]     cfg_wdata,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire pstk_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output pstk_pkg::out_t      out_data
);
	import pstk_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int XW    = (CNT_W > 7) ? CNT_W : 7;

	logic [4:0]       limit_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	status_t          status_s1;
	status_t          status_d;
	logic             pend_q;
	logic             out_valid_q;
	out_t             out_data_q;

	logic   acc;
	logic   rpt;
	logic   out_free;
	logic   full;
	logic   any_term;
	ctl_t   ctl;
	ctl_t   ctl_raw;
	entry_t wr_entry;

	up_link_t   up_w   [STACK_DEPTH+1];
	down_link_t down_w [STACK_DEPTH+1];

	// Handshake: hold the input only when a result is pending and the output
	// cannot drain this cycle.
	assign out_free = ~out_valid_q | ~out_stall;
	assign rpt      = pend_q & out_free;
	assign in_stall = pend_q & ~out_free;
	assign acc      = in_valid & ~in_stall;

	assign full     = count_q == CNT_W'(STACK_DEPTH);
	assign any_term = down_w[0].ge;

	// Push writes the transaction's entry; insert writes a marker with a
	// zero handle and tag.
	always_comb begin
		wr_entry.symbol    = in_data.symbol;
		wr_entry.data_type = in_data.data_type;
		if (in_data.operation == OP_INSERT) begin
			wr_entry.code_handle = '0;
			wr_entry.origin_tag  = '0;
		end else begin
			wr_entry.code_handle = in_data.code_handle;
			wr_entry.origin_tag  = in_data.origin_tag;
		end
	end

	// Decide the new depth and status from the current row.
	always_comb begin
		count_d   = count_q;
		status_d  = ST_OK;
		ctl_raw   = '0;
		unique case (in_data.operation)
			OP_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d         = count_q + 1'b1;
					ctl_raw.push_go = 1'b1;
				end
			end
			OP_POP: begin
				if (XW'(in_data.pop_count) > XW'(count_q)) begin
					count_d  = '0;
					status_d = ST_UNDER;
				end else begin
					count_d = CNT_W'(XW'(count_q) - XW'(in_data.pop_count));
				end
			end
			OP_INSERT: begin
				// A missing terminal is reported before a full stack.
				if (!any_term) begin
					status_d = ST_NOTERM;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d           = count_q + 1'b1;
					ctl_raw.insert_go = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign ctl.push_go   = acc & ctl_raw.push_go;
	assign ctl.insert_go = acc & ctl_raw.insert_go;

	// Row ends: nothing below the bottom cell, nothing above the top cell.
	assign up_w[0]                     = '0;
	assign down_w[STACK_DEPTH]         = '0;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		pstk_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.limit    (limit_q),
			.count    (count_q),
			.ctl      (ctl),
			.wr_entry (wr_entry),
			.up_in    (up_w[i]),
			.down_in  (down_w[i+1]),
			.up_out   (up_w[i+1]),
			.down_out (down_w[i])
		);
	end

	// Control state: limit register, depth, pending result, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= 5'd16;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (acc) begin
				count_q <= count_d;
			end
			if (acc) begin
				pend_q <= 1'b1;
			end else if (rpt) begin
				pend_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= rpt;
			end
		end
	end

	// Status travels with the applied transaction until it is reported.
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
		end
	end

	// Capture the result from the row as it stands after the operation.
	always_ff @(posedge clk) begin
		if (rpt) begin
			out_data_q.status               <= status_s1;
			out_data_q.depth                <= 7'(count_q);
			out_data_q.top_valid            <= count_q != '0;
			out_data_q.top_symbol           <= down_w[0].top_acc.symbol;
			out_data_q.top_data_type        <= down_w[0].top_acc.data_type;
			out_data_q.top_code_handle      <= down_w[0].top_acc.code_handle;
			out_data_q.top_origin_tag       <= down_w[0].top_acc.origin_tag;
			out_data_q.terminal_found       <= down_w[0].ge;
			out_data_q.terminal_symbol      <= down_w[0].term_acc.symbol;
			out_data_q.terminal_data_type   <= down_w[0].term_acc.data_type;
			out_data_q.terminal_code_handle <= down_w[0].term_acc.code_handle;
			out_data_q.terminal_origin_tag  <= down_w[0].term_acc.origin_tag;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_NEVER(a_depth_bound, clk, arst_n, count_q > CNT_W'(STACK_DEPTH), "depth above stack size")
	`ASSERT_CLK(a_push_grows, clk, arst_n, acc && in_data.operation == OP_PUSH && !full |=> count_q == CNT_W'($past(count_q) + 1'b1), "push did not add one entry")
	`ASSERT_CLK(a_report_lands, clk, arst_n, rpt |=> out_valid_q, "pending result not delivered")
	`ASSERT_CLK(a_empty_no_top, clk, arst_n, out_valid_q && !out_data_q.top_valid |-> out_data_q.depth == 7'd0 && !out_data_q.terminal_found, "empty result shows an entry")

endmodule

`default_nettype wire
